[hw/rtl/rqms_pkg.sv]
// Package for the ready queue with minimum select.
// Holds the transaction payload types, the entry layout and the action and status codes.
// No dependencies.
package rqms_pkg;

    localparam logic [2:0] ACT_APPEND    = 3'd0;
    localparam logic [2:0] ACT_POP       = 3'd1;
    localparam logic [2:0] ACT_REMOVE    = 3'd2;
    localparam logic [2:0] ACT_MIN_PRIO  = 3'd3;
    localparam logic [2:0] ACT_MIN_BURST = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  process_id;
        logic [7:0]  priority_req;
        logic [15:0] burst;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  result_id;
        logic [7:0]  result_priority;
        logic [15:0] result_burst;
        logic [4:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [7:0]  id;
    } t_entry;

endpackage

[hw/rtl/rqms_ram.sv]
// Entry store of the ready queue: one write port and one read port with registered data.
// Depends on rqms_pkg for the entry type.
module rqms_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  rqms_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output rqms_pkg::t_entry o_rdata
);

    rqms_pkg::t_entry r_mem [DEPTH];
    rqms_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ready_queue_with_min_select.sv]
// Top level of the ready queue with minimum select: control, walk sequencer and output register.
// Depends on rqms_pkg and rqms_ram.
//
//   Channel | Direction | Handshake                  | Payload
//   input   | in        | i_in_valid / o_in_ready    | i_in_data  (rqms_pkg::t_in_item)
//   output  | out       | o_out_valid / i_out_ready  | o_out_data (rqms_pkg::t_out_item)
//
// An append or an unused action goes from idle straight to the emit state.
// Pop, remove and the two selects walk the entry store once, one read per cycle through
// its single read port, and then go to the emit state; on an empty queue the walk reads nothing.
// The emit state loads the result into the output register once that register is free.
// Reset clears the state, entry count, valid and found flags; the store needs no clearing pass.
// One transaction is in work at a time; a finished result waits in the output register
// while the next transaction is accepted.
module ready_queue_with_min_select #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rqms_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rqms_pkg::t_out_item   o_out_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [2:0]          r_action, n_action;
    logic [7:0]          r_pid, n_pid;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_dv, n_dv;
    logic [AW-1:0]       r_dv_idx, n_dv_idx;
    logic                r_found, n_found;
    rqms_pkg::t_entry    r_best, n_best;
    logic [1:0]          r_status, n_status;
    logic                r_have, n_have;
    logic                r_out_valid, n_out_valid;
    rqms_pkg::t_out_item r_out, n_out;

    logic                in_acc;
    logic                full;
    logic                rd_en;
    logic                we;
    logic [AW-1:0]       waddr;
    rqms_pkg::t_entry    wdata;
    rqms_pkg::t_entry    rdata;
    logic                is_del;
    logic                is_sel;
    logic                match;
    logic                better;
    logic                walk_done;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign full       = (r_count >= DEPTH_C);
    assign is_del     = (r_action == rqms_pkg::ACT_POP) || (r_action == rqms_pkg::ACT_REMOVE);
    assign is_sel     = (r_action == rqms_pkg::ACT_MIN_PRIO)
                        || (r_action == rqms_pkg::ACT_MIN_BURST);
    assign rd_en      = (r_state == S_WALK) && (r_rd_idx < r_count);
    assign walk_done  = (r_state == S_WALK) && (r_rd_idx == r_count) && !r_dv;

    assign match  = ((r_action == rqms_pkg::ACT_POP) && (r_dv_idx == '0))
                    || ((r_action == rqms_pkg::ACT_REMOVE) && (rdata.id == r_pid));
    assign better = (r_action == rqms_pkg::ACT_MIN_PRIO) ? (rdata.prio < r_best.prio)
                                                         : (rdata.burst < r_best.burst);

    always_comb begin
        we    = 1'b0;
        waddr = r_dv_idx - 1'b1;
        wdata = rdata;
        if (in_acc && (i_in_data.action == rqms_pkg::ACT_APPEND) && !full) begin
            we          = 1'b1;
            waddr       = r_count[AW-1:0];
            wdata.burst = i_in_data.burst;
            wdata.prio  = i_in_data.priority_req;
            wdata.id    = i_in_data.process_id;
        end else if ((r_state == S_WALK) && r_dv && r_found) begin
            we = 1'b1;
        end
    end

    rqms_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_action    = r_action;
        n_pid       = r_pid;
        n_rd_idx    = r_rd_idx;
        n_dv        = 1'b0;
        n_dv_idx    = r_rd_idx[AW-1:0];
        n_found     = r_found;
        n_best      = r_best;
        n_status    = r_status;
        n_have      = r_have;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_action = i_in_data.action;
                    n_pid    = i_in_data.process_id;
                    n_rd_idx = '0;
                    n_found  = 1'b0;
                    n_have   = 1'b0;
                    n_status = rqms_pkg::ST_OK;
                    unique case (i_in_data.action)
                        rqms_pkg::ACT_APPEND: begin
                            n_state = S_EMIT;
                            if (full) begin
                                n_status = rqms_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        rqms_pkg::ACT_POP, rqms_pkg::ACT_REMOVE,
                        rqms_pkg::ACT_MIN_PRIO, rqms_pkg::ACT_MIN_BURST: begin
                            n_state = S_WALK;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (rd_en) begin
                    n_dv     = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_dv) begin
                    if (is_del && !r_found && match) begin
                        n_found = 1'b1;
                        n_best  = rdata;
                    end
                    if (is_sel && ((r_dv_idx == '0) || better)) begin
                        n_best = rdata;
                    end
                end
                if (walk_done) begin
                    n_state = S_EMIT;
                    if (is_del) begin
                        n_have = r_found;
                        if (r_found) begin
                            n_status = rqms_pkg::ST_OK;
                            n_count  = r_count - 1'b1;
                        end else if (r_action == rqms_pkg::ACT_POP) begin
                            n_status = rqms_pkg::ST_EMPTY;
                        end else begin
                            n_status = rqms_pkg::ST_NOT_FOUND;
                        end
                    end else begin
                        n_have   = (r_count != '0);
                        n_status = (r_count != '0) ? rqms_pkg::ST_OK : rqms_pkg::ST_EMPTY;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = r_status;
                    n_out.result_id       = r_have ? r_best.id : 8'd0;
                    n_out.result_priority = r_have ? r_best.prio : 8'd0;
                    n_out.result_burst    = r_have ? r_best.burst : 16'd0;
                    n_out.occupancy       = 5'(r_count);
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_pid    <= n_pid;
        r_rd_idx <= n_rd_idx;
        r_dv_idx <= n_dv_idx;
        r_best   <= n_best;
        r_status <= n_status;
        r_have   <= n_have;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("Entry count exceeds the queue depth.");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.action == rqms_pkg::ACT_APPEND) && !full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("Accepted append did not grow the queue.");

    a_shift_only_on_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && r_found)
        |-> ((r_action == rqms_pkg::ACT_POP) || (r_action == rqms_pkg::ACT_REMOVE)))
        else $error("Entries shifted during an action that removes nothing.");
`endif

endmodule
